// ----- hw/rtl/wsd_pkg.sv -----
// Shared types and constants for the work stealing deque.
// Holds the beat structs of both channels and the row control structs.
// No dependencies.
package wsd_pkg;

    localparam int HANDLE_BITS = 16;
    localparam int OCC_BITS    = 9;
    localparam int DEPTH_DEF   = 256;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_STEAL  = 2'd2,
        CMD_REMOVE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd                   cmd;
        logic [HANDLE_BITS-1:0] handle_in;
    } t_in_item;

    typedef struct packed {
        t_status                status;
        logic [HANDLE_BITS-1:0] handle_out;
        logic [OCC_BITS-1:0]    occupancy;
    } t_out_item;

    // Broadcast from the controller to every cell of the row.
    typedef struct packed {
        logic                   shift_up;
        logic                   shift_dn;
        logic                   launch;
        logic                   steal;
        logic                   clr_en;
        logic                   clr_head;
        logic [HANDLE_BITS-1:0] key;
    } t_row_cmd;

    // Search token that walks from the head cell down to cell 0.
    typedef struct packed {
        logic                   valid;
        logic                   steal;
        logic                   hit;
        logic [HANDLE_BITS-1:0] data;
    } t_tok;

endpackage

// ----- hw/rtl/work_stealing_deque.sv -----
// Top level of the work stealing deque: sequencer plus a row of handle cells.
// Depends on wsd_pkg, wsd_ctrl and wsd_row.
//
//   channel   direction  beat type            handshake
//   in        input      wsd_pkg::t_in_item   i_in_valid / o_in_stall
//   out       output     wsd_pkg::t_out_item  o_out_valid / i_out_stall
//
// A push ends in the execute state; a pop stays there while holes drop at the tail.
// Steal and remove send a token from the head cell down the row one cell per cycle,
// so that walk sets their rate.
// Reset clears the occupied flags and counters at once; no clearing pass is needed.
// A new beat is taken only when the previous command has finished; a stalled result
// waits in a hold register; no new beat is taken until the output takes it.
module work_stealing_deque #(
    parameter int DEPTH = wsd_pkg::DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  wsd_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output wsd_pkg::t_out_item o_out_data
);

    localparam int NC     = DEPTH - 1;
    localparam int CIDX_W = (NC > 1) ? $clog2(NC) : 1;

    wsd_pkg::t_row_cmd               row_cmd;
    logic [CIDX_W-1:0]               clr_idx;
    logic [wsd_pkg::HANDLE_BITS-1:0] tail_val;
    wsd_pkg::t_tok                   tok;
    logic [CIDX_W-1:0]               tok_idx;

    wsd_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .o_row_cmd   (row_cmd),
        .o_clr_idx   (clr_idx),
        .i_tail_val  (tail_val),
        .i_tok       (tok),
        .i_tok_idx   (tok_idx)
    );

    wsd_row #(
        .DEPTH (DEPTH)
    ) u_row (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (row_cmd),
        .i_clr_idx  (clr_idx),
        .o_tail_val (tail_val),
        .o_tok      (tok),
        .o_tok_idx  (tok_idx)
    );

endmodule

// ----- hw/rtl/wsd_cell.sv -----
// One cell of the deque row: a handle, an occupied flag and a token stage.
// Depends on wsd_pkg for the row command and token structs.
module wsd_cell #(
    parameter int IDX    = 0,
    parameter int CIDX_W = 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  wsd_pkg::t_row_cmd               i_cmd,
    input  logic [CIDX_W-1:0]               i_clr_idx,
    input  logic [wsd_pkg::HANDLE_BITS-1:0] i_below_val,
    input  logic                            i_below_occ,
    input  logic [wsd_pkg::HANDLE_BITS-1:0] i_above_val,
    input  logic                            i_above_occ,
    input  wsd_pkg::t_tok                   i_above_tok,
    input  logic [CIDX_W-1:0]               i_above_idx,
    output logic [wsd_pkg::HANDLE_BITS-1:0] o_val,
    output logic                            o_occ,
    output wsd_pkg::t_tok                   o_tok,
    output logic [CIDX_W-1:0]               o_idx
);

    localparam logic [CIDX_W-1:0] MY_IDX = CIDX_W'(IDX);

    logic [wsd_pkg::HANDLE_BITS-1:0] r_val, n_val;
    logic                            r_occ, n_occ;
    wsd_pkg::t_tok                   r_tok, n_tok;
    logic [CIDX_W-1:0]               r_idx, n_idx;
    wsd_pkg::t_tok                   tok_in;
    logic [CIDX_W-1:0]               idx_in;
    logic                            is_head;

    assign is_head = r_occ && !i_above_occ;

    always_comb begin
        tok_in = i_above_tok;
        idx_in = i_above_idx;
        // The head cell starts a new search in place of an empty stage above.
        if (!i_above_tok.valid && i_cmd.launch && is_head) begin
            tok_in.valid = 1'b1;
            tok_in.steal = i_cmd.steal;
            tok_in.hit   = 1'b0;
            tok_in.data  = '0;
            idx_in       = '0;
        end

        n_tok = tok_in;
        n_idx = idx_in;
        n_val = r_val;
        n_occ = r_occ;

        if (tok_in.valid) begin
            if (tok_in.steal) begin
                // A steal consumes every cell it passes until a real handle turns up.
                if (!tok_in.hit) begin
                    n_occ = 1'b0;
                    if (r_val != '0) begin
                        n_tok.hit  = 1'b1;
                        n_tok.data = r_val;
                        n_idx      = MY_IDX;
                    end
                end
            end else if (r_val == i_cmd.key) begin
                // Lower cells pass later, so the match nearest the tail wins.
                n_tok.hit = 1'b1;
                n_idx     = MY_IDX;
            end
        end

        if (i_cmd.shift_up) begin
            n_val = i_below_val;
            n_occ = i_below_occ;
        end else if (i_cmd.shift_dn) begin
            n_val = i_above_val;
            n_occ = i_above_occ;
        end else if (i_cmd.clr_en && (i_clr_idx == MY_IDX)) begin
            n_val = '0;
            if (i_cmd.clr_head) begin
                n_occ = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_idx <= n_idx;
        if (!i_rst_n) begin
            r_occ <= 1'b0;
            r_tok <= '0;
        end else begin
            r_occ <= n_occ;
            r_tok <= n_tok;
        end
    end

    assign o_val = r_val;
    assign o_occ = r_occ;
    assign o_tok = r_tok;
    assign o_idx = r_idx;

endmodule

// ----- hw/rtl/wsd_row.sv -----
// Row of deque cells, tail at cell 0 and head at the highest occupied cell.
// Depends on wsd_pkg and wsd_cell.
module wsd_row #(
    parameter int DEPTH = wsd_pkg::DEPTH_DEF,
    localparam int NC     = DEPTH - 1,
    localparam int CIDX_W = (NC > 1) ? $clog2(NC) : 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  wsd_pkg::t_row_cmd               i_cmd,
    input  logic [CIDX_W-1:0]               i_clr_idx,
    output logic [wsd_pkg::HANDLE_BITS-1:0] o_tail_val,
    output wsd_pkg::t_tok                   o_tok,
    output logic [CIDX_W-1:0]               o_tok_idx
);

    logic [wsd_pkg::HANDLE_BITS-1:0] val [NC];
    logic                            occ [NC];
    wsd_pkg::t_tok                   tok [NC];
    logic [CIDX_W-1:0]               tidx [NC];

    for (genvar g = 0; g < NC; g++) begin : g_cell
        logic [wsd_pkg::HANDLE_BITS-1:0] below_val;
        logic                            below_occ;
        logic [wsd_pkg::HANDLE_BITS-1:0] above_val;
        logic                            above_occ;
        wsd_pkg::t_tok                   above_tok;
        logic [CIDX_W-1:0]               above_idx;

        if (g == 0) begin : g_bot
            // A push shifts the new handle into the tail cell.
            assign below_val = i_cmd.key;
            assign below_occ = 1'b1;
        end else begin : g_mid_bot
            assign below_val = val[g-1];
            assign below_occ = occ[g-1];
        end

        if (g == NC - 1) begin : g_top
            assign above_val = '0;
            assign above_occ = 1'b0;
            assign above_tok = '0;
            assign above_idx = '0;
        end else begin : g_mid_top
            assign above_val = val[g+1];
            assign above_occ = occ[g+1];
            assign above_tok = tok[g+1];
            assign above_idx = tidx[g+1];
        end

        wsd_cell #(
            .IDX    (g),
            .CIDX_W (CIDX_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (i_cmd),
            .i_clr_idx   (i_clr_idx),
            .i_below_val (below_val),
            .i_below_occ (below_occ),
            .i_above_val (above_val),
            .i_above_occ (above_occ),
            .i_above_tok (above_tok),
            .i_above_idx (above_idx),
            .o_val       (val[g]),
            .o_occ       (occ[g]),
            .o_tok       (tok[g]),
            .o_idx       (tidx[g])
        );
    end

    assign o_tail_val = val[0];
    assign o_tok      = tok[0];
    assign o_tok_idx  = tidx[0];

endmodule

// ----- hw/rtl/wsd_ctrl.sv -----
// Command sequencer, entry counter and output register of the deque.
// Depends on wsd_pkg; drives the broadcast into wsd_row.
module wsd_ctrl #(
    parameter int DEPTH = wsd_pkg::DEPTH_DEF,
    localparam int NC     = DEPTH - 1,
    localparam int CIDX_W = (NC > 1) ? $clog2(NC) : 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  wsd_pkg::t_in_item               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output wsd_pkg::t_out_item              o_out_data,
    output wsd_pkg::t_row_cmd               o_row_cmd,
    output logic [CIDX_W-1:0]               o_clr_idx,
    input  logic [wsd_pkg::HANDLE_BITS-1:0] i_tail_val,
    input  wsd_pkg::t_tok                   i_tok,
    input  logic [CIDX_W-1:0]               i_tok_idx
);

    localparam int PTR_W  = $clog2(DEPTH) + 1;
    localparam logic [PTR_W-1:0] FULL_CNT = PTR_W'(DEPTH - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_WAIT = 4'b0100,
        S_RESP = 4'b1000
    } t_state;

    t_state                          r_state, n_state;
    logic [PTR_W-1:0]                r_count, n_count;
    wsd_pkg::t_cmd                   r_op;
    logic [wsd_pkg::HANDLE_BITS-1:0] r_key;
    wsd_pkg::t_out_item              r_res, n_res;
    wsd_pkg::t_out_item              r_out, res;
    logic                            r_ov, n_ov;
    logic                            done, load_out, out_free;
    wsd_pkg::t_row_cmd               row_cmd;
    logic [CIDX_W-1:0]               clr_idx;

    assign out_free = !r_ov || !i_out_stall;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_res    = r_res;
        done     = 1'b0;
        load_out = 1'b0;
        res      = '0;
        res.status = wsd_pkg::ST_MISS;
        row_cmd  = '0;
        row_cmd.key = r_key;
        clr_idx  = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_op)
                    wsd_pkg::CMD_PUSH: begin
                        done = 1'b1;
                        if (r_count >= FULL_CNT) begin
                            res.status = wsd_pkg::ST_FULL;
                        end else begin
                            row_cmd.shift_up = 1'b1;
                            n_count    = r_count + 1'b1;
                            res.status = wsd_pkg::ST_OK;
                        end
                    end
                    wsd_pkg::CMD_POP: begin
                        if (r_count == '0) begin
                            done = 1'b1;
                        end else begin
                            // Holes at the tail are dropped one per cycle.
                            row_cmd.shift_dn = 1'b1;
                            n_count = r_count - 1'b1;
                            if (i_tail_val != '0) begin
                                done           = 1'b1;
                                res.status     = wsd_pkg::ST_OK;
                                res.handle_out = i_tail_val;
                            end
                        end
                    end
                    wsd_pkg::CMD_STEAL: begin
                        if (r_count == '0) begin
                            done = 1'b1;
                        end else begin
                            row_cmd.launch = 1'b1;
                            row_cmd.steal  = 1'b1;
                            n_state        = S_WAIT;
                        end
                    end
                    wsd_pkg::CMD_REMOVE: begin
                        if ((r_key == '0) || (r_count == '0)) begin
                            done = 1'b1;
                        end else begin
                            row_cmd.launch = 1'b1;
                            n_state        = S_WAIT;
                        end
                    end
                    default: begin
                        done = 1'b1;
                    end
                endcase
            end
            S_WAIT: begin
                if (i_tok.valid) begin
                    done = 1'b1;
                    if (i_tok.steal) begin
                        // Everything from the hit cell up to the old head is gone.
                        n_count = i_tok.hit ? PTR_W'(i_tok_idx) : '0;
                        if (i_tok.hit) begin
                            res.status     = wsd_pkg::ST_OK;
                            res.handle_out = i_tok.data;
                        end
                    end else if (i_tok.hit) begin
                        res.status = wsd_pkg::ST_OK;
                        if (i_tok_idx == '0) begin
                            row_cmd.shift_dn = 1'b1;
                            n_count = r_count - 1'b1;
                        end else begin
                            row_cmd.clr_en = 1'b1;
                            clr_idx        = i_tok_idx;
                            if (PTR_W'(i_tok_idx) == r_count - 1'b1) begin
                                row_cmd.clr_head = 1'b1;
                                n_count = r_count - 1'b1;
                            end
                        end
                    end
                end
            end
            S_RESP: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        res.occupancy = wsd_pkg::OCC_BITS'(n_count);

        if (done) begin
            if (out_free) begin
                load_out = 1'b1;
                n_state  = S_IDLE;
            end else begin
                n_res   = res;
                n_state = S_RESP;
            end
        end

        n_ov = load_out ? 1'b1 : (r_ov && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (r_state == S_IDLE && i_in_valid) begin
            r_op  <= i_in_data.cmd;
            r_key <= i_in_data.handle_in;
        end
        if (load_out) begin
            r_out <= (r_state == S_RESP) ? r_res : res;
        end
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ov    <= n_ov;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;
    assign o_row_cmd   = row_cmd;
    assign o_clr_idx   = clr_idx;

endmodule
